FILE: rtl/ksa_pkg.sv
// package: op and status codes, shared types for the sample statistics engine
package ksa_pkg;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_KEY_FULL  = 3'd2;
    localparam logic [2:0] ST_ADDED     = 3'd3;
    localparam logic [2:0] ST_EXISTS    = 3'd4;
    localparam logic [2:0] ST_ALRT_FULL = 3'd5;
    localparam logic [2:0] ST_REMOVED   = 3'd6;
    localparam logic [2:0] ST_CLEARED   = 3'd7;

    localparam int IN_BITS  = 2 + 64 + 32 + 64 + 32 + 32 + 16;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS  = 3 + 32 * 5 + 1 + 16;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        key_tag;
        logic signed [31:0] sample_value;
        logic [63:0]        alert_tag;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [15:0]        owner_user;
    } t_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] stat_last;
        logic signed [31:0] stat_min;
        logic signed [31:0] stat_max;
        logic signed [31:0] stat_avg;
        logic [31:0]        stat_count;
        logic               alert_fired;
        logic [15:0]        alert_user;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word, reset scan
        logic key_step;   // advance key scan
        logic alrt_step;  // advance alert scan
        logic div_start;
        logic div_step;
        logic key_write;  // write updated or inserted key entry
        logic alrt_add;
        logic shift_step; // move alert j+1 to j
        logic alrt_dec;
        logic clear_keys;
        logic mk_result;
        logic [2:0] status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic key_end;    // key scan past used entries
        logic key_hit;
        logic key_full;
        logic alrt_end;
        logic alrt_id_hit;
        logic alrt_key_hit;
        logic alrt_full;
        logic shift_end;
        logic div_done;
    } t_stat;

endpackage

FILE: rtl/ksa_ctrl.sv
// controller: sequences scans, divide, alert compaction and result hand-off
module ksa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_busy,
    output ksa_pkg::t_cmd  o_cmd,
    input  ksa_pkg::t_stat i_stat
);
    import ksa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KSCAN  = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_KWR    = 4'd3;
    localparam logic [3:0] S_ASCAN  = 4'd4;
    localparam logic [3:0] S_IDSCAN = 4'd5;
    localparam logic [3:0] S_SHIFT  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;

    logic [3:0] r_state, n_state;
    logic [2:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_UPDATED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_stat.op == OP_SAMPLE) ? S_KSCAN : S_IDSCAN;
                end
            end
            S_KSCAN: begin
                if (i_stat.op == OP_CLEAR) begin
                    o_cmd.clear_keys = 1'b1;
                    n_status = ST_CLEARED;
                    n_state = S_DONE;
                end else if (i_stat.key_hit) begin
                    o_cmd.div_start = 1'b1;
                    n_status = ST_UPDATED;
                    n_state = S_DIV;
                end else if (i_stat.key_end) begin
                    if (i_stat.key_full) begin
                        n_status = ST_KEY_FULL;
                        n_state = S_DONE;
                    end else begin
                        n_status = ST_INSERTED;
                        n_state = S_KWR;
                    end
                end else begin
                    o_cmd.key_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) n_state = S_KWR;
            end
            S_KWR: begin
                o_cmd.key_write = 1'b1;
                n_state = S_ASCAN;
            end
            S_ASCAN: begin
                if (i_stat.alrt_key_hit || i_stat.alrt_end) n_state = S_DONE;
                else o_cmd.alrt_step = 1'b1;
            end
            S_IDSCAN: begin
                if (i_stat.op == OP_CLEAR) begin
                    n_state = S_KSCAN;
                end else if (i_stat.alrt_id_hit) begin
                    if (i_stat.op == OP_ADD) begin
                        n_status = ST_EXISTS;
                        n_state = S_DONE;
                    end else begin
                        n_status = ST_REMOVED;
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.alrt_end) begin
                    if (i_stat.op == OP_REMOVE) begin
                        n_status = ST_REMOVED;
                    end else if (i_stat.alrt_full) begin
                        n_status = ST_ALRT_FULL;
                    end else begin
                        o_cmd.alrt_add = 1'b1;
                        n_status = ST_ADDED;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.alrt_step = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_end) begin
                    o_cmd.alrt_dec = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.mk_result = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

FILE: rtl/ksa_div.sv
// iterative signed 64 by 32 divide, one quotient bit a cycle while i_step is high, truncating
module ksa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_step,
    input  logic [63:0] i_dividend,  // signed
    input  logic [31:0] i_divisor,   // unsigned, nonzero
    output logic [31:0] o_quot,
    output logic        o_done
);
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic [31:0] r_dvs;
    logic [32:0] w_sub;

    assign w_sub = {r_rem[63:32], r_quo[63]} - {1'b0, r_dvs};
    assign o_done = (r_cnt == 7'd64);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 7'd64;
        end else if (i_start) begin
            r_cnt <= 7'd0;
        end else if (i_step && !o_done) begin
            r_cnt <= r_cnt + 7'd1;
        end
    end

    // shift the next dividend bit into the partial remainder
    always_comb begin
        n_rem = {r_rem[62:32], r_quo[63], 32'd0};
        if (!w_sub[32]) n_rem[63:32] = w_sub[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[63];
            r_quo <= i_dividend[63] ? (64'd0 - i_dividend) : i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (i_step && !o_done) begin
            // remainder kept in upper half; it stays below the divisor
            r_rem <= {n_rem[63:32], 32'd0};
            r_quo <= {r_quo[62:0], !w_sub[32]};
        end
    end

    // quotient fits 32 bits: it lies between old average and the value
    assign o_quot = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];
endmodule

FILE: rtl/ksa_datapath.sv
// datapath: key and alert tables, scan pointers, statistics update, result register
module ksa_datapath #(
    parameter int KEY_ENTRIES   = 16,
    parameter int ALERT_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ksa_pkg::t_item   i_item,
    input  ksa_pkg::t_cmd    i_cmd,
    output ksa_pkg::t_stat   o_stat,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output ksa_pkg::t_result o_result
);
    import ksa_pkg::*;

    localparam int KW = $clog2(KEY_ENTRIES + 1);
    localparam int AW = $clog2(ALERT_ENTRIES + 1);
    localparam int KI = (KEY_ENTRIES > 1) ? $clog2(KEY_ENTRIES) : 1;
    localparam int AI = (ALERT_ENTRIES > 1) ? $clog2(ALERT_ENTRIES) : 1;

    logic [63:0] r_ktag [KEY_ENTRIES];
    logic [31:0] r_klast[KEY_ENTRIES];
    logic [31:0] r_kmin [KEY_ENTRIES];
    logic [31:0] r_kmax [KEY_ENTRIES];
    logic [31:0] r_kavg [KEY_ENTRIES];
    logic [31:0] r_kcnt [KEY_ENTRIES];
    logic [63:0] r_aid  [ALERT_ENTRIES];
    logic [63:0] r_akey [ALERT_ENTRIES];
    logic [31:0] r_alo  [ALERT_ENTRIES];
    logic [31:0] r_ahi  [ALERT_ENTRIES];
    logic [15:0] r_aown [ALERT_ENTRIES];

    logic [KW-1:0] r_kused, r_kp;
    logic [AW-1:0] r_aused, r_ap;
    t_item         r_item;
    t_result       r_res, n_res;
    logic          r_ovalid;
    logic signed [31:0] r_nmin, r_nmax;
    logic [31:0]   r_ncnt;
    logic          r_fired;
    logic [15:0]   r_user;

    logic [KI-1:0] w_ki;
    logic [AI-1:0] w_ai, w_ai1;
    logic [31:0]   w_cnt, w_quot;
    logic [63:0]   w_acc;
    logic          w_div_done;
    logic signed [31:0] w_v;

    assign w_v  = r_item.sample_value;
    assign w_ki = r_kp[KI-1:0];
    assign w_ai = r_ap[AI-1:0];
    assign w_ai1 = AI'(r_ap + AW'(1));

    assign o_stat.op           = (i_cmd.load) ? i_item.op : r_item.op;
    assign o_stat.key_end      = (r_kp >= r_kused);
    assign o_stat.key_hit      = (r_kp < r_kused) && (r_ktag[w_ki] == r_item.key_tag);
    assign o_stat.key_full     = (r_kused >= KW'(KEY_ENTRIES));
    assign o_stat.alrt_end     = (r_ap >= r_aused);
    assign o_stat.alrt_id_hit  = (r_ap < r_aused) && (r_aid[w_ai] == r_item.alert_tag);
    assign o_stat.alrt_key_hit = (r_ap < r_aused) && (r_akey[w_ai] == r_item.key_tag);
    assign o_stat.alrt_full    = (r_aused >= AW'(ALERT_ENTRIES));
    assign o_stat.shift_end    = (r_ap + AW'(1) >= r_aused);
    assign o_stat.div_done     = w_div_done;

    // saturating count and 64-bit accumulator avg*(n-1)+v
    assign w_cnt = (r_kcnt[w_ki] == 32'hffff_ffff) ? r_kcnt[w_ki] : r_kcnt[w_ki] + 32'd1;
    logic signed [63:0] w_prod;
    assign w_prod = $signed(r_kavg[w_ki]) * $signed({1'b0, w_cnt - 32'd1});
    logic signed [63:0] r_prod;
    assign w_acc = r_prod + 64'(w_v);

    // product registered at the start; divide launched in the next cycle via r_dstart
    logic r_dstart;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dstart <= 1'b0;
        else          r_dstart <= i_cmd.div_start;
        if (i_cmd.div_start) begin
            r_prod <= w_prod;
            r_ncnt <= w_cnt;
            r_nmin <= (w_v < $signed(r_kmin[w_ki])) ? w_v : $signed(r_kmin[w_ki]);
            r_nmax <= (w_v > $signed(r_kmax[w_ki])) ? w_v : $signed(r_kmax[w_ki]);
        end
    end

    logic w_div_raw;
    ksa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_step     (i_cmd.div_step && !r_dstart),
        .i_dividend (w_acc),
        .i_divisor  (r_ncnt),
        .o_quot     (w_quot),
        .o_done     (w_div_raw)
    );
    assign w_div_done = w_div_raw && !r_dstart && !i_cmd.div_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kused  <= '0;
            r_aused  <= '0;
            r_kp     <= '0;
            r_ap     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_kp <= '0;
                r_ap <= '0;
            end
            if (i_cmd.key_step) r_kp <= r_kp + KW'(1);
            if (i_cmd.alrt_step || i_cmd.shift_step) r_ap <= r_ap + AW'(1);
            if (i_cmd.key_write && i_cmd.status == ST_INSERTED) r_kused <= r_kused + KW'(1);
            if (i_cmd.clear_keys) r_kused <= '0;
            if (i_cmd.alrt_add) r_aused <= r_aused + AW'(1);
            if (i_cmd.alrt_dec) r_aused <= r_aused - AW'(1);
            if (i_cmd.key_write) r_ap <= '0;
            if (i_cmd.mk_result) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    // result word: stats and alert only for samples that found or inserted a key
    always_comb begin
        n_res = '0;
        n_res.status = i_cmd.status;
        if (i_cmd.status == ST_UPDATED || i_cmd.status == ST_INSERTED) begin
            n_res.stat_last   = r_klast[w_ki];
            n_res.stat_min    = r_kmin[w_ki];
            n_res.stat_max    = r_kmax[w_ki];
            n_res.stat_avg    = r_kavg[w_ki];
            n_res.stat_count  = r_kcnt[w_ki];
            n_res.alert_fired = r_fired;
            n_res.alert_user  = r_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_item;
            r_fired <= 1'b0;
            r_user  <= '0;
        end
        if (i_cmd.key_write) begin
            r_ktag[w_ki] <= r_item.key_tag;
            r_klast[w_ki] <= w_v;
            if (i_cmd.status == ST_INSERTED) begin
                r_kmin[w_ki] <= w_v;
                r_kmax[w_ki] <= w_v;
                r_kavg[w_ki] <= w_v;
                r_kcnt[w_ki] <= 32'd1;
            end else begin
                r_kmin[w_ki] <= r_nmin;
                r_kmax[w_ki] <= r_nmax;
                r_kavg[w_ki] <= w_quot;
                r_kcnt[w_ki] <= r_ncnt;
            end
        end
        if (o_stat.alrt_key_hit && !i_cmd.alrt_step && r_item.op == OP_SAMPLE
                && !i_cmd.key_write && !i_cmd.load) begin
            if (w_v < $signed(r_alo[w_ai]) || w_v > $signed(r_ahi[w_ai])) begin
                r_fired <= 1'b1;
                r_user  <= r_aown[w_ai];
            end
        end
        if (i_cmd.alrt_add) begin
            r_aid[w_ai]  <= r_item.alert_tag;
            r_akey[w_ai] <= r_item.key_tag;
            r_alo[w_ai]  <= r_item.range_low;
            r_ahi[w_ai]  <= r_item.range_high;
            r_aown[w_ai] <= r_item.owner_user;
        end
        if (i_cmd.shift_step) begin
            r_aid[w_ai]  <= r_aid[w_ai1];
            r_akey[w_ai] <= r_akey[w_ai1];
            r_alo[w_ai]  <= r_alo[w_ai1];
            r_ahi[w_ai]  <= r_ahi[w_ai1];
            r_aown[w_ai] <= r_aown[w_ai1];
        end
        if (i_cmd.mk_result) r_res <= n_res;
    end

    assign o_out_valid = r_ovalid;
    assign o_result    = r_res;
endmodule

FILE: rtl/keyed_sample_stats_with_range_alerts.sv
// top level: keyed sample statistics table with range alerts
//  channel | dir | handshake         | word
//  s_axis  | in  | tvalid/tready     | op,key_tag,sample_value,alert_tag,range_low,range_high,owner_user
//  m_axis  | out | tvalid/tready     | status,stat_last,stat_min,stat_max,stat_avg,stat_count,
//          |     |                   | alert_fired,alert_user
// one word at a time; a sample scans the key list, then for an update launches and steps
// the divide, writes the key entry and scans the alert list for an alert on that key
// alert ops scan the alert list by tag, and removal moves each later entry up one slot;
// clear passes through the alert scan to the key scan state, which empties the key table
// result register holds a word while m_axis stalls; the next word waits for it
// synchronous active-low reset empties both tables
module keyed_sample_stats_with_range_alerts #(
    parameter int KEY_ENTRIES   = 16,
    parameter int ALERT_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // op, key_tag, sample_value, alert_tag, range_low, range_high, owner_user, zero pad
    input  logic [ksa_pkg::IN_BYTES*8-1:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status, stat_last, stat_min, stat_max, stat_avg, stat_count, alert_fired,
    // alert_user, zero pad
    output logic [ksa_pkg::OUT_BYTES*8-1:0] m_axis_tdata
);
    import ksa_pkg::*;

    t_item   w_item;
    t_result w_res;
    t_cmd    w_cmd;
    t_stat   w_stat;

    assign w_item.op           = s_axis_tdata[1:0];
    assign w_item.key_tag      = s_axis_tdata[65:2];
    assign w_item.sample_value = s_axis_tdata[97:66];
    assign w_item.alert_tag    = s_axis_tdata[161:98];
    assign w_item.range_low    = s_axis_tdata[193:162];
    assign w_item.range_high   = s_axis_tdata[225:194];
    assign w_item.owner_user   = s_axis_tdata[241:226];

    assign m_axis_tdata = {(OUT_BYTES*8 - OUT_BITS)'(0), w_res.alert_user, w_res.alert_fired,
        w_res.stat_count, w_res.stat_avg, w_res.stat_max, w_res.stat_min,
        w_res.stat_last, w_res.status};

    ksa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_busy (m_axis_tvalid && !m_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    ksa_datapath #(
        .KEY_ENTRIES   (KEY_ENTRIES),
        .ALERT_ENTRIES (ALERT_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (w_res)
    );
endmodule
